// ===== rtl/crg_pkg.sv =====
// Shared types and constants for the camera ray generator.
// No dependencies.
package crg_pkg;
   localparam int FRAC_BITS = 16;
   localparam int LANE_W = 20;            // Q4.16 lane width
   localparam int VEC_W = 3 * LANE_W;     // packed x,y,z
   localparam int COORD_W = 17;
   localparam int SCALE_W = 20;           // scaled coordinate width
   localparam int TERM_W = 25;            // axis * scale >> FRAC_BITS
   localparam int D_W = 28;               // direction component
   localparam int SQ_W = 54;              // one squared component
   localparam int LEN2_W = 56;            // sum of squares
   localparam int ROOT_W = 27;            // floor square root
   localparam int NUM_W = 44;             // divider numerator
   localparam int QUO_W = 17;             // divider quotient
   localparam int DIR_W = 18;
   localparam int IDX_W = 8;

   localparam logic [IDX_W-1:0] REG_EYE    = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_RIGHT  = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_UP     = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_CORNER = IDX_W'(3);
   localparam logic [IDX_W-1:0] REG_WIDTH  = IDX_W'(4);
   localparam logic [IDX_W-1:0] REG_HEIGHT = IDX_W'(5);

   localparam logic [COORD_W-1:0] ONE_FX = COORD_W'(1) << FRAC_BITS;

   typedef logic signed [D_W-1:0] dval_type;
   typedef logic [ROOT_W-1:0] root_type;
   typedef logic [QUO_W-1:0] quo_type;

   // camera settings seen by the datapath
   typedef struct packed {
      logic [VEC_W-1:0]   eye;
      logic [VEC_W-1:0]   right;
      logic [VEC_W-1:0]   up;
      logic [VEC_W-1:0]   corner;
      logic [LANE_W-1:0]  width;
      logic [LANE_W-1:0]  height;
   } cam_cfg_type;

   // pipeline control shared by all stages
   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;

   function automatic logic signed [LANE_W-1:0] lane(input logic [VEC_W-1:0] v, input int k);
      lane = $signed(v[k*LANE_W +: LANE_W]);
   endfunction
endpackage

// ===== rtl/crg_if.sv =====
// Channel interfaces for the camera ray generator: request, response, config.
// Depends on crg_pkg.
interface crg_req_if import crg_pkg::*; ();
   logic valid;
   logic ready;
   logic [COORD_W-1:0] coord_u;
   logic [COORD_W-1:0] coord_v;
   modport source (output valid, coord_u, coord_v, input ready);
   modport sink (input valid, coord_u, coord_v, output ready);
endinterface

interface crg_rsp_if import crg_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [LANE_W-1:0] origin_x;
   logic signed [LANE_W-1:0] origin_y;
   logic signed [LANE_W-1:0] origin_z;
   logic signed [DIR_W-1:0] dir_x;
   logic signed [DIR_W-1:0] dir_y;
   logic signed [DIR_W-1:0] dir_z;
   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 output ready);
endinterface

interface crg_csr_if import crg_pkg::*; ();
   logic valid;
   logic ready;
   logic [IDX_W-1:0] index;
   logic [VEC_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/crg_front.sv =====
// Front stages: coordinate scaling, axis terms, direction and squared length.
// Depends on crg_pkg.
module crg_front import crg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  pipe_ctl_type         ctl,
   input  logic [COORD_W-1:0]   coord_u,
   input  logic [COORD_W-1:0]   coord_v,
   input  cam_cfg_type          cfg,
   output logic                 out_valid,
   output dval_type             out_d [3],
   output logic [LEN2_W-1:0]    out_len2
);
   logic [4:0] v_ff;
   logic [SCALE_W-1:0] su_ff, sv_ff;
   logic signed [TERM_W-1:0] tr_ff [3], tu_ff [3];
   dval_type d3_ff [3], d4_ff [3], d5_ff [3];
   logic [SQ_W-1:0] sq_ff [3];
   logic [LEN2_W-1:0] len2_ff;

   logic [COORD_W-1:0] uc, vc;
   logic [COORD_W+LANE_W-1:0] pu, pv;
   logic signed [LANE_W+SCALE_W:0] pr [3], pp [3];
   logic signed [2*D_W-1:0] dsq [3];

   // clamp and scale the coordinates
   always_comb begin
      uc = (coord_u > ONE_FX) ? ONE_FX : coord_u;
      vc = (coord_v > ONE_FX) ? ONE_FX : coord_v;
      pu = (COORD_W+LANE_W)'(uc) * (COORD_W+LANE_W)'(cfg.width);
      pv = (COORD_W+LANE_W)'(vc) * (COORD_W+LANE_W)'(cfg.height);
   end

   // axis products and squares
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pr[k] = (LANE_W+SCALE_W+1)'(lane(cfg.right, k)) * $signed({1'b0, su_ff});
         pp[k] = (LANE_W+SCALE_W+1)'(lane(cfg.up, k)) * $signed({1'b0, sv_ff});
         dsq[k] = d3_ff[k] * d3_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (ctl.en) begin
         v_ff <= {v_ff[3:0], ctl.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         su_ff <= SCALE_W'(pu >> FRAC_BITS);
         sv_ff <= SCALE_W'(pv >> FRAC_BITS);
         for (int k = 0; k < 3; k++) begin
            tr_ff[k] <= TERM_W'(pr[k] >>> FRAC_BITS);
            tu_ff[k] <= TERM_W'(pp[k] >>> FRAC_BITS);
            d3_ff[k] <= D_W'(lane(cfg.corner, k)) + D_W'(tr_ff[k]) + D_W'(tu_ff[k])
                        - D_W'(lane(cfg.eye, k));
            d4_ff[k] <= d3_ff[k];
            sq_ff[k] <= SQ_W'(dsq[k]);
            d5_ff[k] <= d4_ff[k];
         end
         len2_ff <= LEN2_W'(sq_ff[0]) + LEN2_W'(sq_ff[1]) + LEN2_W'(sq_ff[2]);
      end
   end

   assign out_valid = v_ff[4];
   assign out_d = d5_ff;
   assign out_len2 = len2_ff;
endmodule

// ===== rtl/crg_sqrt.sv =====
// Pipelined floor square root, one root bit per stage.
// Depends on crg_pkg.
module crg_sqrt import crg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  pipe_ctl_type         ctl,
   input  dval_type             in_d [3],
   input  logic [LEN2_W-1:0]    in_len2,
   output logic                 out_valid,
   output dval_type             out_d [3],
   output root_type             out_len
);
   logic [ROOT_W:1] v_ff;
   logic [LEN2_W-1:0] rem_ff [1:ROOT_W];
   root_type root_ff [1:ROOT_W];
   dval_type d_ff [1:ROOT_W][3];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_step
      localparam int B = ROOT_W - 1 - s;
      logic v_cur;
      logic [LEN2_W-1:0] rem_cur;
      root_type root_cur;
      dval_type d_cur [3];
      logic [LEN2_W-1:0] cand;

      // stage input: the module ports for the first stage, else the previous stage
      if (s == 0) begin : g_first
         assign v_cur = ctl.valid;
         assign rem_cur = in_len2;
         assign root_cur = '0;
         assign d_cur = in_d;
      end else begin : g_next
         assign v_cur = v_ff[s];
         assign rem_cur = rem_ff[s];
         assign root_cur = root_ff[s];
         assign d_cur = d_ff[s];
      end

      // trial subtrahend 2*root*2^B + 4^B
      assign cand = (LEN2_W'(root_cur) << (B + 1)) | (LEN2_W'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (ctl.en) begin
            v_ff[s+1] <= v_cur;
         end
      end
      always_ff @(posedge clock) begin
         if (ctl.en) begin
            d_ff[s+1] <= d_cur;
            if (rem_cur >= cand) begin
               rem_ff[s+1] <= rem_cur - cand;
               root_ff[s+1] <= root_cur | (root_type'(1) << B);
            end else begin
               rem_ff[s+1] <= rem_cur;
               root_ff[s+1] <= root_cur;
            end
         end
      end
   end

   assign out_valid = v_ff[ROOT_W];
   assign out_d = d_ff[ROOT_W];
   assign out_len = root_ff[ROOT_W];
endmodule

// ===== rtl/crg_div.sv =====
// Pipelined rounding divider: |d| * 2^FRAC_BITS / len, one quotient bit per stage.
// Depends on crg_pkg.
module crg_div import crg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  pipe_ctl_type         ctl,
   input  dval_type             in_d [3],
   input  root_type             in_len,
   output logic                 out_valid,
   output logic [2:0]           out_neg,
   output logic                 out_zero,
   output quo_type              out_q [3]
);
   logic [QUO_W:1] v_ff;
   logic [NUM_W-1:0] rem_ff [1:QUO_W][3];
   quo_type q_ff [1:QUO_W][3];
   root_type len_ff [1:QUO_W];
   logic [2:0] neg_ff [1:QUO_W];
   logic [D_W-1:0] mag [3];
   logic [NUM_W-1:0] rem0 [3];
   logic [2:0] neg0;

   // numerator setup: magnitude shifted up plus half the divisor
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag[k] = in_d[k][D_W-1] ? D_W'(-in_d[k]) : D_W'(in_d[k]);
         rem0[k] = (NUM_W'(mag[k]) << FRAC_BITS) + NUM_W'(in_len >> 1);
         neg0[k] = in_d[k][D_W-1];
      end
   end

   for (genvar s = 0; s < QUO_W; s++) begin : g_step
      localparam int B = QUO_W - 1 - s;
      logic v_cur;
      root_type len_cur;
      logic [2:0] neg_cur;
      logic [NUM_W-1:0] rem_cur [3];
      quo_type q_cur [3];
      logic [NUM_W-1:0] cmp;

      // stage input: the setup logic for the first stage, else the previous stage
      if (s == 0) begin : g_first
         assign v_cur = ctl.valid;
         assign len_cur = in_len;
         assign neg_cur = neg0;
         assign rem_cur = rem0;
         assign q_cur = '{default: '0};
      end else begin : g_next
         assign v_cur = v_ff[s];
         assign len_cur = len_ff[s];
         assign neg_cur = neg_ff[s];
         assign rem_cur = rem_ff[s];
         assign q_cur = q_ff[s];
      end

      assign cmp = NUM_W'(len_cur) << B;
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (ctl.en) begin
            v_ff[s+1] <= v_cur;
         end
      end
      always_ff @(posedge clock) begin
         if (ctl.en) begin
            len_ff[s+1] <= len_cur;
            neg_ff[s+1] <= neg_cur;
            for (int k = 0; k < 3; k++) begin
               if (rem_cur[k] >= cmp) begin
                  rem_ff[s+1][k] <= rem_cur[k] - cmp;
                  q_ff[s+1][k] <= q_cur[k] | (quo_type'(1) << B);
               end else begin
                  rem_ff[s+1][k] <= rem_cur[k];
                  q_ff[s+1][k] <= q_cur[k];
               end
            end
         end
      end
   end

   assign out_valid = v_ff[QUO_W];
   assign out_neg = neg_ff[QUO_W];
   assign out_zero = (len_ff[QUO_W] == '0);
   assign out_q = q_ff[QUO_W];
endmodule

// ===== rtl/camera_ray_generator_top.sv =====
// Pipeline: 5 front, 27 root, 17 divide and 1 output register stage from request to response.
// Throughput: one transaction per cycle; the whole pipeline holds when rsp stalls.
// Rate is set by the fully pipelined square-root and divider bit stages.
// Reset: synchronous, clears all valid bits and loads register reset values.
// Top level of the camera ray generator. Depends on crg_pkg, crg_if and submodules.
module camera_ray_generator_top import crg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   crg_req_if.sink     req,
   crg_rsp_if.source   rsp,
   crg_csr_if.sink     csr
);
   cam_cfg_type cfg_ff;
   pipe_ctl_type ctl;
   logic en;

   logic f_valid, s_valid, q_valid, q_zero;
   dval_type f_d [3], s_d [3];
   logic [LEN2_W-1:0] f_len2;
   root_type s_len;
   logic [2:0] q_neg;
   quo_type q_q [3];

   logic rsp_v_ff;
   logic signed [DIR_W-1:0] dir_ff [3];
   logic signed [DIR_W-1:0] dir_in [3];

   // configuration registers
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.eye <= '0;
         cfg_ff.right <= '0;
         cfg_ff.up <= '0;
         cfg_ff.corner <= '0;
         cfg_ff.width <= LANE_W'(131072);
         cfg_ff.height <= LANE_W'(131072);
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_EYE:    cfg_ff.eye <= csr.data;
            REG_RIGHT:  cfg_ff.right <= csr.data;
            REG_UP:     cfg_ff.up <= csr.data;
            REG_CORNER: cfg_ff.corner <= csr.data;
            REG_WIDTH:  cfg_ff.width <= csr.data[LANE_W-1:0];
            REG_HEIGHT: cfg_ff.height <= csr.data[LANE_W-1:0];
            default: ;
         endcase
      end
   end

   // global pipeline advance
   assign en = !rsp_v_ff || rsp.ready;
   assign req.ready = en;
   assign ctl = '{en: en, valid: req.valid};

   crg_front u_front (
      .clock(clock), .reset(reset), .ctl(ctl),
      .coord_u(req.coord_u), .coord_v(req.coord_v), .cfg(cfg_ff),
      .out_valid(f_valid), .out_d(f_d), .out_len2(f_len2)
   );

   crg_sqrt u_sqrt (
      .clock(clock), .reset(reset), .ctl('{en: en, valid: f_valid}),
      .in_d(f_d), .in_len2(f_len2),
      .out_valid(s_valid), .out_d(s_d), .out_len(s_len)
   );

   crg_div u_div (
      .clock(clock), .reset(reset), .ctl('{en: en, valid: s_valid}),
      .in_d(s_d), .in_len(s_len),
      .out_valid(q_valid), .out_neg(q_neg), .out_zero(q_zero), .out_q(q_q)
   );

   // saturate to one, apply sign, zero for a zero-length direction
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [QUO_W-1:0] r;
         r = (q_q[k] > ONE_FX) ? ONE_FX : q_q[k];
         if (q_zero) begin
            dir_in[k] = '0;
         end else if (q_neg[k]) begin
            dir_in[k] = -$signed(DIR_W'(r));
         end else begin
            dir_in[k] = $signed(DIR_W'(r));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         rsp_v_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dir_ff <= dir_in;
      end
   end

   assign rsp.valid = rsp_v_ff;
   assign rsp.origin_x = lane(cfg_ff.eye, 0);
   assign rsp.origin_y = lane(cfg_ff.eye, 1);
   assign rsp.origin_z = lane(cfg_ff.eye, 2);
   assign rsp.dir_x = dir_ff[0];
   assign rsp.dir_y = dir_ff[1];
   assign rsp.dir_z = dir_ff[2];
endmodule
